[hdl/rgb_vibrance_adjust_top_macros.svh]
// Assertion macros shared by the vibrance adjust block.
`ifndef RGB_VIBRANCE_ADJUST_TOP_MACROS_SVH
`define RGB_VIBRANCE_ADJUST_TOP_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define RGBVA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds whenever the block is out of reset.
`define RGBVA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

[hdl/rgbva_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbva_pkg
// Constants and types shared by the vibrance adjust pipeline.
// ----------------------------------------------------------------------------
package rgbva_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned FIELD_W          = 16;
  localparam int unsigned FRAC_BITS        = 16;
  localparam int unsigned QUOT_BITS        = FRAC_BITS + 1;
  localparam int unsigned BITS_W           = 5;
  localparam int unsigned INDEX_W          = 4;

  localparam logic [15:0] LUMA_R  = 16'd19595;
  localparam logic [15:0] LUMA_G  = 16'd38470;
  localparam logic [15:0] LUMA_B  = 16'd7471;
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  // floor(x / 10) = (x * RECIP_10) >> RECIP_SHIFT for every x below 699050.
  localparam logic [18:0] RECIP_10    = 19'd419431;
  localparam int unsigned RECIP_SHIFT = 22;

  localparam logic [INDEX_W-1:0] REG_AMOUNT = 4'd0;
  localparam logic [INDEX_W-1:0] REG_BITS   = 4'd1;

  localparam logic [15:0]       AMOUNT_RST = 16'd16384;
  localparam logic [BITS_W-1:0] BITS_RST   = 5'd8;

  typedef struct packed {
    logic en;
    logic valid;
  } rgbva_pipe_ctl_t;

endpackage

[hdl/rgbva_div_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbva_div_pipe
// Pipelined restoring divider, one quotient bit per stage, for d/m with d<=m.
// ----------------------------------------------------------------------------
module rgbva_div_pipe
  import rgbva_pkg::*;
#(
  parameter int unsigned WIDTH  = SAMPLE_WIDTH_DEF,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rgbva_pipe_ctl_t      ctl_i,
  input  logic [WIDTH-1:0]     num_i,
  input  logic [WIDTH-1:0]     den_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [QUOT_BITS-1:0] quot_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic                 v_q    [QUOT_BITS];
  logic [WIDTH:0]       rem_q  [QUOT_BITS];
  logic [WIDTH-1:0]     den_q  [QUOT_BITS];
  logic [QUOT_BITS-1:0] quot_q [QUOT_BITS];
  logic [SIDE_W-1:0]    side_q [QUOT_BITS];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
    logic [WIDTH:0]       rem_in;
    logic [WIDTH-1:0]     den_in;
    logic [QUOT_BITS-1:0] quot_in;
    logic [SIDE_W-1:0]    side_in;
    logic                 v_in;
    logic                 take;
    logic [WIDTH:0]       rem_sub;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, num_i};
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
      assign v_in    = ctl_i.valid;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign take    = rem_in >= {1'b0, den_in};
    assign rem_sub = take ? (rem_in - {1'b0, den_in}) : rem_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        v_q[k] <= v_in;
      end
    end

    // The remainder stays below the divisor, so doubling it fits WIDTH+1 bits.
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k]  <= {rem_sub[WIDTH-1:0], 1'b0};
        den_q[k]  <= den_in;
        quot_q[k] <= {quot_in[QUOT_BITS-2:0], take};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[QUOT_BITS-1];
  assign quot_o  = quot_q[QUOT_BITS-1];
  assign side_o  = side_q[QUOT_BITS-1];

endmodule

[hdl/rgb_vibrance_adjust_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_vibrance_adjust_top
// Vibrance adjustment of an RGB pixel stream with skin tone protection.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Word
//  s_axis    in         s_axis_tvalid/tready    input pixel (red, green, blue)
//  m_axis    out        m_axis_tvalid/tready    adjusted pixel (red, green, blue)
//  cfg       in         cfg_valid_i/cfg_ready_o register index and write data
//
// One pixel is accepted in every clock cycle while the pipeline advances; each word
// passes through the input and extremes stages, the 17 stages of the saturation
// divider, and the weight, boost and mixing stages to the output register.
// The whole pipeline advances together whenever the output register is empty
// or being read, so a stall downstream freezes every stage and loses nothing.
// Reset clears every valid bit and loads amount 1.0 and 8 bits per sample.
// Configuration writes are always accepted; the sample maximum is read at the
// input and output stages and the amount at the boost stage, so the user must
// write registers only while no word is in flight; the block does not enforce it.
//
module rgb_vibrance_adjust_top
  import rgbva_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input pixel stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [3*FIELD_W-1:0] s_axis_tdata,  // red_in, green_in, blue_in
  // Output pixel stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [3*FIELD_W-1:0] m_axis_tdata,  // red_out, green_out, blue_out
  // Register writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [INDEX_W-1:0]   cfg_index_i,
  input  logic [FIELD_W-1:0]   cfg_data_i
);

  localparam int unsigned S      = SAMPLE_WIDTH;
  localparam int unsigned SIDE_W = 3 * S + 2;
  localparam int unsigned LUMA_W = S + 16;
  localparam int unsigned DIFF_W = S + 17;
  localparam int unsigned PH_W   = S + 18;
  localparam int unsigned V_W    = S + 36;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0]       amount_q;
  logic [BITS_W-1:0] bits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amount_q <= AMOUNT_RST;
      bits_q   <= BITS_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_AMOUNT) amount_q <= cfg_data_i;
      if (cfg_index_i == REG_BITS)   bits_q   <= cfg_data_i[BITS_W-1:0];
    end
  end

  // Sample maximum: a zero bit count counts as one, an excess as the full width.
  logic [BITS_W-1:0] bits_eff;
  logic [S-1:0]      maxv;

  always_comb begin
    bits_eff = bits_q;
    if (bits_q == '0) bits_eff = BITS_W'(1);
    if (bits_q > BITS_W'(S)) bits_eff = BITS_W'(S);
    maxv = {S{1'b1}} >> (BITS_W'(S) - bits_eff);
  end

  // The whole pipeline moves as one whenever the output register can take a word.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Stage 0: input samples saturated to the maximum
  // --------------------------------------------------------------------------
  logic         v0_q;
  logic [S-1:0] c0_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (s_axis_tdata[i*FIELD_W +: FIELD_W] > FIELD_W'(maxv)) c0_q[i] <= maxv;
        else c0_q[i] <= s_axis_tdata[i*FIELD_W +: S];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: extremes and the skin tone test
  // --------------------------------------------------------------------------
  logic         v1_q;
  logic [S-1:0] c1_q [3];
  logic [S-1:0] mx1_q, mn1_q;
  logic         skin1_q;

  logic [S-1:0] mx_d, mn_d;
  logic [S+3:0] num10, den3, den7;
  logic         skin_d;

  always_comb begin
    mx_d = c0_q[0];
    mn_d = c0_q[0];
    for (int i = 1; i < 3; i++) begin
      if (c0_q[i] > mx_d) mx_d = c0_q[i];
      if (c0_q[i] < mn_d) mn_d = c0_q[i];
    end
    // Products only matter when red > green > blue, so the differences are positive.
    num10  = (S+4)'(c0_q[1] - c0_q[2]) * (S+4)'(10);
    den3   = (S+4)'(c0_q[0] - c0_q[2]) * (S+4)'(3);
    den7   = (S+4)'(c0_q[0] - c0_q[2]) * (S+4)'(7);
    skin_d = (c0_q[0] > c0_q[1]) && (c0_q[1] > c0_q[2]) && (num10 > den3) && (num10 < den7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q    <= c0_q;
      mx1_q   <= mx_d;
      mn1_q   <= mn_d;
      skin1_q <= skin_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: (max - min) * 2^16 / max, the HSV saturation in sixteen fraction bits
  // --------------------------------------------------------------------------
  rgbva_pipe_ctl_t      div_ctl;
  logic [SIDE_W-1:0]    div_side_in, div_side_out;
  logic                 dv;
  logic [QUOT_BITS-1:0] quot;

  assign div_ctl.en    = en;
  assign div_ctl.valid = v1_q;
  assign div_side_in   = {c1_q[2], c1_q[1], c1_q[0], skin1_q, (mx1_q == '0)};

  rgbva_div_pipe #(
    .WIDTH  (S),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (div_ctl),
    .num_i   (mx1_q - mn1_q),
    .den_i   (mx1_q),
    .side_i  (div_side_in),
    .valid_o (dv),
    .quot_o  (quot),
    .side_o  (div_side_out)
  );

  logic         dzero, dskin;
  logic [S-1:0] dc [3];

  assign dzero = div_side_out[0];
  assign dskin = div_side_out[1];
  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign dc[i] = div_side_out[2 + i*S +: S];
  end

  // --------------------------------------------------------------------------
  // Stage W1: weight and luma products
  // --------------------------------------------------------------------------
  logic              vw1_q;
  logic [16:0]       w1_q;
  logic              skin_w1_q;
  logic [S-1:0]      cw1_q [3];
  logic [LUMA_W-1:0] lp_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vw1_q <= 1'b0;
    else if (en) vw1_q <= dv;
  end

  // A black pixel counts as fully unsaturated.
  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_q      <= dzero ? 17'h10000 : (17'h10000 - quot);
      skin_w1_q <= dskin;
      cw1_q     <= dc;
      lp_q[0]   <= LUMA_W'(dc[0]) * LUMA_W'(LUMA_R);
      lp_q[1]   <= LUMA_W'(dc[1]) * LUMA_W'(LUMA_G);
      lp_q[2]   <= LUMA_W'(dc[2]) * LUMA_W'(LUMA_B);
    end
  end

  // --------------------------------------------------------------------------
  // Stage W2: skin cut to three tenths, rounded half up, and the luma sum
  // --------------------------------------------------------------------------
  logic              vw2_q;
  logic [16:0]       w2_q;
  logic [S-1:0]      cw2_q [3];
  logic [LUMA_W-1:0] luma2_q;

  logic [18:0] cut_x;
  logic [37:0] cut_p;

  assign cut_x = 19'(w1_q) * 19'd3 + 19'd5;
  assign cut_p = 38'(cut_x) * 38'(RECIP_10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vw2_q <= 1'b0;
    else if (en) vw2_q <= vw1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w2_q    <= skin_w1_q ? cut_p[RECIP_SHIFT +: 17] : w1_q;
      cw2_q   <= cw1_q;
      luma2_q <= lp_q[0] + lp_q[1] + lp_q[2];
    end
  end

  // --------------------------------------------------------------------------
  // Stage B1: (amount - 1) * weight
  // --------------------------------------------------------------------------
  logic               vb1_q;
  logic signed [34:0] bprod_q;
  logic [S-1:0]       cb1_q [3];
  logic [LUMA_W-1:0]  luma_b1_q;
  logic signed [16:0] amt_m1;

  assign amt_m1 = $signed({1'b0, amount_q}) - $signed({1'b0, ONE_Q14});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb1_q <= 1'b0;
    else if (en) vb1_q <= vw2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bprod_q   <= 35'(amt_m1) * 35'($signed({1'b0, w2_q}));
      cb1_q     <= cw2_q;
      luma_b1_q <= luma2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B2: boost in Q2.14 and the channel differences from luma
  // --------------------------------------------------------------------------
  logic                     vb2_q;
  logic [15:0]              boost_q;
  logic signed [DIFF_W-1:0] diff_q [3];
  logic [LUMA_W-1:0]        luma_b2_q;
  logic signed [35:0]       bsum;

  // The boost never falls below zero nor exceeds sixteen bits.
  assign bsum = 36'sh040000000 + 36'(bprod_q) + 36'sh000008000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb2_q <= 1'b0;
    else if (en) vb2_q <= vb1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      boost_q   <= bsum[31:16];
      luma_b2_q <= luma_b1_q;
      for (int i = 0; i < 3; i++) begin
        diff_q[i] <= $signed({1'b0, cb1_q[i], 16'h0000}) - $signed({1'b0, luma_b1_q});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage M1: difference times boost, split into high and low partial products
  // --------------------------------------------------------------------------
  logic                   vm1_q;
  logic signed [PH_W-1:0] ph_q [3];
  logic [31:0]            pl_q [3];
  logic [LUMA_W-1:0]      luma_m1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm1_q <= 1'b0;
    else if (en) vm1_q <= vb2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      luma_m1_q <= luma_b2_q;
      for (int i = 0; i < 3; i++) begin
        ph_q[i] <= PH_W'($signed(diff_q[i][DIFF_W-1:16])) * PH_W'($signed({1'b0, boost_q}));
        pl_q[i] <= diff_q[i][15:0] * boost_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage M2: mix, clamp and round into the output register
  // --------------------------------------------------------------------------
  logic                  out_v_q;
  logic [FIELD_W-1:0]    out_q [3];
  logic signed [V_W-1:0] vmix [3];
  logic signed [V_W-1:0] vtop;
  logic signed [V_W-1:0] vrnd [3];
  logic [S-1:0]          res  [3];

  always_comb begin
    vtop = $signed({{(V_W-S-30){1'b0}}, maxv, 30'd0});
    for (int i = 0; i < 3; i++) begin
      vmix[i] = $signed({{(V_W-LUMA_W-14){1'b0}}, luma_m1_q, 14'd0})
              + $signed({{(V_W-PH_W-16){ph_q[i][PH_W-1]}}, ph_q[i], 16'd0})
              + $signed({{(V_W-32){1'b0}}, pl_q[i]});
      vrnd[i] = vmix[i] + $signed(V_W'(1) <<< 29);
      if (vmix[i] <= 0) res[i] = '0;
      else if (vmix[i] >= vtop) res[i] = maxv;
      else res[i] = vrnd[i][30 +: S];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= vm1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) out_q[i] <= FIELD_W'(res[i]);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q[2], out_q[1], out_q[0]};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `include "rgb_vibrance_adjust_top_macros.svh"

  `RGBVA_ASSERT_IMP(a_quot_range, dv && !dzero, quot <= 17'h10000, "saturation above one")
  `RGBVA_ASSERT_IMP(a_weight_range, vw2_q, w2_q <= 17'h10000, "weight above one")
  `RGBVA_ASSERT_IMP(a_out_max, out_v_q,
    (out_q[0] <= FIELD_W'(maxv)) && (out_q[1] <= FIELD_W'(maxv)) &&
    (out_q[2] <= FIELD_W'(maxv)), "output sample above maximum")

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vibrance adjust block testbench
// Feeds RGB pixels through the stream input under several idling patterns,
// predicts every adjusted pixel in fixed point and compares each output word
// with the oldest prediction. Register settings change only while idle.
// ----------------------------------------------------------------------------
module testbench;
  import rgbva_pkg::*;

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [3*FIELD_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [3*FIELD_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [INDEX_W-1:0] cfg_index_i = '0;
  logic [FIELD_W-1:0] cfg_data_i = '0;

  rgb_vibrance_adjust_top dut (.*);

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The predictor keeps its own copy of the two registers.
  logic [15:0] pred_amount = AMOUNT_RST;
  logic [4:0]  pred_bits   = BITS_RST;

  pixel_t pending_pixels[$];
  pixel_t expected_pixels[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;   // percentage of cycles in which the driver idles
  int recv_stall_pct = 0;  // percentage of cycles in which the monitor stalls
  logic hold_off = 1'b0;   // long receiver hold-off, timed by its own process

  // One output channel: luma plus the scaled difference, clamped to [0, M].
  function automatic logic [15:0] mix_sample(input logic [15:0] c, input longint luma,
                                             input longint boost, input longint maxv);
    longint v;
    v = luma * 16384 + (longint'(c) * 65536 - luma) * boost;
    if (v <= 0) return 16'd0;
    if (v >= maxv * (longint'(1) << 30)) return maxv[15:0];
    return 16'((v + (longint'(1) << 29)) >>> 30);
  endfunction

  function automatic pixel_t vibrance_of(input pixel_t px);
    int unsigned nbits;
    longint maxv, r, g, b, mx, mn, wgt, boost, luma;
    pixel_t res;
    nbits = pred_bits;
    if (nbits == 0) nbits = 1;
    if (nbits > 16) nbits = 16;
    maxv = (longint'(1) << nbits) - 1;
    // Samples above the maximum saturate before any work.
    r = (px.red > maxv) ? maxv : px.red;
    g = (px.green > maxv) ? maxv : px.green;
    b = (px.blue > maxv) ? maxv : px.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    // A black pixel counts as unsaturated.
    wgt = (mx == 0) ? 65536 : 65536 - (((mx - mn) << 16) / mx);
    // Skin tones keep only three tenths of their weight.
    if (r > g && g > b && (g - b) * 10 > (r - b) * 3 && (g - b) * 10 < (r - b) * 7)
      wgt = (wgt * 3 + 5) / 10;
    boost = ((longint'(1) << 30) + (longint'(pred_amount) - 16384) * wgt + 32768) >>> 16;
    luma = 19595 * r + 38470 * g + 7471 * b;
    res.red   = mix_sample(r[15:0], luma, boost, maxv);
    res.green = mix_sample(g[15:0], luma, boost, maxv);
    res.blue  = mix_sample(b[15:0], luma, boost, maxv);
    return res;
  endfunction

  // Driver: offers queued pixels and predicts each one as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(vibrance_of(pixel_t'(s_axis_tdata)));
        void'(pending_pixels.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_pixels[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every accepted word with the oldest prediction.
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = pixel_t'(m_axis_tdata);
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue, got.red, got.green, got.blue);
          end
        end
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_AMOUNT) pred_amount = val;
    else if (idx == REG_BITS) pred_bits = val[4:0];
  endtask

  // Pushing the word here is safe: the driver only pops on acceptance.
  task automatic queue_pixel(input logic [15:0] r, g, b);
    pixel_t px;
    px.red = r; px.green = g; px.blue = b;
    pending_pixels.push_back(px);
  endtask

  // Waits until every queued pixel has been accepted and answered.
  task automatic drain;
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // A random pixel: mostly within the current sample range, sometimes any
  // 16-bit value, sometimes a skin-like ordering or grey.
  task automatic random_pixel;
    int unsigned nbits, maxv, r, g, b;
    nbits = (pred_bits == 0) ? 1 : (pred_bits > 16 ? 16 : pred_bits);
    maxv = (1 << nbits) - 1;
    r = $urandom_range(maxv); g = $urandom_range(maxv); b = $urandom_range(maxv);
    case ($urandom_range(9))
      0, 1: begin r = $urandom_range(65535); g = $urandom_range(65535);
              b = $urandom_range(65535); end
      2, 3: begin b = $urandom_range(maxv / 3); r = $urandom_range(maxv, b);
              g = b + (r - b) * $urandom_range(25, 75) / 100; end
      4: begin g = r; b = r; end
      default: ;
    endcase
    queue_pixel(r[15:0], g[15:0], b[15:0]);
  endtask

  typedef struct { logic [15:0] amt; logic [15:0] nbits; int sidle; int rstall; } phase_t;

  initial begin
    phase_t phases[7];
    phases[0] = '{16'd16384, 16'd8, 0, 0};
    phases[1] = '{16'd32768, 16'd16, 88, 0};
    phases[2] = '{16'd0, 16'd1, 0, 88};
    phases[3] = '{16'd65535, 16'd0, 6, 6};
    phases[4] = '{16'd8000, 16'd31, 0, 0};
    phases[5] = '{16'd24576, 16'd10, 30, 30};
    phases[6] = '{16'd20000, 16'd12, 0, 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed pixels at the reset setting: extremes, black, grey, skin.
    queue_pixel(16'd0, 16'd0, 16'd0);
    queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_pixel(16'hFFFF, 16'd0, 16'd0);
    queue_pixel(16'd0, 16'hFFFF, 16'd0);
    queue_pixel(16'd0, 16'd0, 16'hFFFF);
    queue_pixel(16'd255, 16'd128, 16'd0);
    queue_pixel(16'd200, 16'd150, 16'd100);
    queue_pixel(16'd200, 16'd130, 16'd100);
    queue_pixel(16'd200, 16'd170, 16'd100);
    queue_pixel(16'd100, 16'd100, 16'd100);
    queue_pixel(16'h5555, 16'hAAAA, 16'h1234);
    drain();
    write_reg(REG_AMOUNT, 16'd65535);
    write_reg(4'd9, 16'd3);  // unknown index, no effect
    queue_pixel(16'd255, 16'd128, 16'd0);
    queue_pixel(16'd10, 16'd20, 16'd30);
    queue_pixel(16'd200, 16'd150, 16'd100);
    drain();

    foreach (phases[p]) begin
      write_reg(REG_AMOUNT, phases[p].amt);
      write_reg(REG_BITS, phases[p].nbits);
      send_idle_pct  = phases[p].sidle;
      recv_stall_pct = phases[p].rstall;
      if (p == 6) begin
        // Long receiver hold-off while the sender keeps the block full.
        fork
          begin
            hold_off = 1'b1;
            repeat (150) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
        repeat (120) random_pixel();
      end else begin
        repeat (100) random_pixel();
      end
      drain();
    end

    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule
